/* rtl/bed_pkg.sv */
// Shared types, character constants and decode functions for the backslash escape decoder.
// Used by every module of the block; depends on nothing.
package bed_pkg;

	// Escape characters
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X_LO      = 8'h78;
	localparam logic [7:0] CH_X_UP      = 8'h58;

	// Numeric escapes stop after this many digits
	localparam logic [1:0] MAX_DIGITS = 2'd3;

	// Depth of the queue between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	// Parser phase, one-hot
	typedef enum logic [3:0] {
		PH_PLAIN   = 4'b0001,
		PH_ESC     = 4'b0010,
		PH_DIGITS  = 4'b0100,
		PH_AFTER_X = 4'b1000
	} bed_phase_t;

	// One result word
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
	} bed_res_t;

	// Results caused by one input word; second is used when two is set
	typedef struct packed {
		bed_res_t first;
		bed_res_t second;
		logic     two;
	} bed_entry_t;

	// Queue head as seen by the back end
	typedef struct packed {
		bed_entry_t head;
		logic       empty;
	} bed_qhead_t;

	// Control escape letter: {hit, code}
	function automatic logic [8:0] ctl_lookup(input logic [7:0] b);
		logic [8:0] r;
		case (b)
			8'h6E:        r = {1'b1, 8'h0A}; // n
			8'h74:        r = {1'b1, 8'h09}; // t
			8'h72:        r = {1'b1, 8'h0D}; // r
			8'h66:        r = {1'b1, 8'h0C}; // f
			8'h62:        r = {1'b1, 8'h08}; // b
			8'h76:        r = {1'b1, 8'h0B}; // v
			8'h61:        r = {1'b1, 8'h07}; // a
			CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
			default:      r = 9'd0;
		endcase
		return r;
	endfunction

	// Octal digit test; the value is then b[2:0]
	function automatic logic is_octal(input logic [7:0] b);
		return (b inside {[8'h30:8'h37]});
	endfunction

	// Hex digit: {ok, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [7:0] t;
		logic [4:0] r;
		r = 5'd0;
		if (b inside {[8'h30:8'h39]}) begin
			t = b - 8'h30;
			r = {1'b1, t[3:0]};
		end else if (b inside {[8'h61:8'h66]}) begin
			t = b - 8'h57;
			r = {1'b1, t[3:0]};
		end else if (b inside {[8'h41:8'h46]}) begin
			t = b - 8'h37;
			r = {1'b1, t[3:0]};
		end
		return r;
	endfunction

endpackage

/* rtl/bed_in_if.sv */
// Input channel of the backslash escape decoder: one text byte per word.
// Standalone interface; no dependencies.
interface bed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/bed_out_if.sv */
// Output channel of the backslash escape decoder: one decoded result per word.
// Standalone interface; no dependencies.
interface bed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_end;

	modport source (output valid, output out_byte, output out_valid, output out_end,
		input ready);
	modport sink   (input valid, input out_byte, input out_valid, input out_end,
		output ready);
endinterface

/* rtl/bed_front.sv */
// Front end: accepts text bytes, runs the escape parser and builds the results of each byte.
// Depends on bed_pkg and bed_in_if.
module bed_front import bed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bed_in_if.sink     din,
	input  logic       full,
	output logic       push,
	output bed_entry_t entry
);

	bed_phase_t ph_q, ph_n;
	logic [7:0] val_q, val_n;
	logic [1:0] cnt_q, cnt_n;
	logic       hex_q, hex_n;

	logic [7:0] b;
	logic       accept;
	logic [8:0] ctl;
	logic [4:0] hd;
	logic       oct;
	logic       dig_ok;
	logic [7:0] acc;
	logic [1:0] cnt_inc;
	logic [1:0] n;
	bed_res_t   r0, r1;

	assign b         = din.in_byte;
	assign din.ready = !full;
	assign accept    = din.valid && din.ready;
	assign ctl       = ctl_lookup(b);
	assign hd        = hex_digit(b);
	assign oct       = is_octal(b);
	assign dig_ok    = hex_q ? hd[4] : oct;
	assign acc       = hex_q ? {val_q[3:0], hd[3:0]} : {val_q[4:0], b[2:0]};
	assign cnt_inc   = cnt_q + 2'd1;

	// Parse one byte: next state and up to two results
	always_comb begin
		ph_n  = ph_q;
		val_n = val_q;
		cnt_n = cnt_q;
		hex_n = hex_q;
		r0    = '0;
		r1    = '0;
		n     = 2'd0;
		case (ph_q)
			PH_PLAIN: begin
				if (b == CH_BACKSLASH) begin
					ph_n = PH_ESC;
				end else begin
					r0 = '{data: b, has_byte: 1'b1, last: 1'b0};
					n  = 2'd1;
				end
			end
			PH_ESC: begin
				if (ctl[8]) begin
					r0   = '{data: ctl[7:0], has_byte: 1'b1, last: 1'b0};
					n    = 2'd1;
					ph_n = PH_PLAIN;
				end else if (oct) begin
					val_n = {5'd0, b[2:0]};
					cnt_n = 2'd1;
					hex_n = 1'b0;
					ph_n  = PH_DIGITS;
				end else if (b == CH_X_LO || b == CH_X_UP) begin
					val_n = 8'd0;
					cnt_n = 2'd0;
					hex_n = 1'b1;
					ph_n  = PH_AFTER_X;
				end else begin
					ph_n = PH_PLAIN;
				end
			end
			PH_AFTER_X: begin
				if (hd[4]) begin
					val_n = {4'd0, hd[3:0]};
					cnt_n = 2'd1;
					ph_n  = PH_DIGITS;
				end else begin
					// x with no hex digit: emit zero, drop the byte
					r0    = '{data: 8'd0, has_byte: 1'b1, last: 1'b0};
					n     = 2'd1;
					ph_n  = PH_PLAIN;
					val_n = 8'd0;
					cnt_n = 2'd0;
					hex_n = 1'b0;
				end
			end
			PH_DIGITS: begin
				if (dig_ok) begin
					if (cnt_inc == MAX_DIGITS || cnt_inc == 2'd0) begin
						r0    = '{data: acc, has_byte: 1'b1, last: 1'b0};
						n     = 2'd1;
						ph_n  = PH_PLAIN;
						val_n = 8'd0;
						cnt_n = 2'd0;
						hex_n = 1'b0;
					end else begin
						val_n = acc;
						cnt_n = cnt_inc;
					end
				end else begin
					// Non-digit ends the number; a backslash then starts a new escape, any other byte is plain text
					r0    = '{data: val_q, has_byte: 1'b1, last: 1'b0};
					val_n = 8'd0;
					cnt_n = 2'd0;
					hex_n = 1'b0;
					if (b == CH_BACKSLASH) begin
						ph_n = PH_ESC;
						n    = 2'd1;
					end else begin
						ph_n = PH_PLAIN;
						r1   = '{data: b, has_byte: 1'b1, last: 1'b0};
						n    = 2'd2;
					end
				end
			end
			default: begin
				ph_n  = PH_PLAIN;
				val_n = 8'd0;
				cnt_n = 2'd0;
				hex_n = 1'b0;
			end
		endcase

		// End of string: flush a pending number, mark the last result or add an end-only one
		if (din.in_last) begin
			if (ph_n == PH_DIGITS || ph_n == PH_AFTER_X) begin
				if (n == 2'd0) begin
					r0 = '{data: (ph_n == PH_DIGITS) ? val_n : 8'd0, has_byte: 1'b1,
						last: 1'b0};
				end else begin
					r1 = '{data: (ph_n == PH_DIGITS) ? val_n : 8'd0, has_byte: 1'b1,
						last: 1'b0};
				end
				n = n + 2'd1;
			end
			if (n == 2'd0) begin
				r0 = '{data: 8'd0, has_byte: 1'b0, last: 1'b1};
				n  = 2'd1;
			end else if (n == 2'd1) begin
				r0.last = 1'b1;
			end else begin
				r1.last = 1'b1;
			end
			ph_n  = PH_PLAIN;
			val_n = 8'd0;
			cnt_n = 2'd0;
			hex_n = 1'b0;
		end
	end

	assign push  = accept && (n != 2'd0);
	assign entry = '{first: r0, second: r1, two: (n == 2'd2)};

	// Advance parser state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_PLAIN;
			val_q <= 8'd0;
			cnt_q <= 2'd0;
			hex_q <= 1'b0;
		end else if (accept) begin
			ph_q  <= ph_n;
			val_q <= val_n;
			cnt_q <= cnt_n;
			hex_q <= hex_n;
		end
	end

endmodule

/* rtl/bed_queue.sv */
// Short queue of result entries between the parser front end and the output back end.
// Depends on bed_pkg.
module bed_queue import bed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bed_entry_t entry,
	output logic       full,
	input  logic       pop,
	output bed_qhead_t qhead
);

	bed_entry_t     slots_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign full        = (cnt_q == (QAW+1)'(QDEPTH));
	assign qhead.empty = (cnt_q == '0);
	assign qhead.head  = slots_q[rd_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/bed_back.sv */
// Back end: splits queue entries into single result words behind an output register.
// Depends on bed_pkg and bed_out_if.
module bed_back import bed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bed_qhead_t qhead,
	output logic       pop,
	bed_out_if.source  dout
);

	bed_res_t res_q;
	logic     vld_q;
	logic     idx_q;
	logic     load;
	bed_res_t cur;

	assign load = !qhead.empty && (!vld_q || dout.ready);
	assign cur  = idx_q ? qhead.head.second : qhead.head.first;
	assign pop  = load && (idx_q || !qhead.head.two);

	// Hold the result register until taken, refill from the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= !pop;
		end else if (dout.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= cur;
		end
	end

	assign dout.valid     = vld_q;
	assign dout.out_byte  = res_q.data;
	assign dout.out_valid = res_q.has_byte;
	assign dout.out_end   = res_q.last;

endmodule

/* rtl/backslash_escape_decoder.sv */
// C-style backslash escape decoder. Takes one text byte per cycle while the queue has room
// and gives decoded bytes, one result word per cycle while the output is ready; a byte that
// yields two results (a number closed by a plain character) gives them as two words. The
// front end's parser accepts a byte every cycle while the four-entry result queue has room;
// the output register then drains one result a cycle while dout.ready is high, so input
// stalls only when the output side is slower than the text. An accepted byte's results are
// first written into the queue and then loaded into the output register. The last result of
// each string has out_end set; it can be an end-only word with out_valid low.
// Depends on bed_pkg, bed_in_if, bed_out_if, bed_front, bed_queue and bed_back.
module backslash_escape_decoder import bed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bed_in_if.sink    din,
	bed_out_if.source dout
);

	logic       push;
	logic       full;
	logic       pop;
	bed_entry_t entry;
	bed_qhead_t qhead;

	bed_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.full   (full),
		.push   (push),
		.entry  (entry)
	);

	bed_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.full   (full),
		.pop    (pop),
		.qhead  (qhead)
	);

	bed_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qhead  (qhead),
		.pop    (pop),
		.dout   (dout)
	);

`ifndef SYNTH
	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qhead.empty)
		else $error("pop from empty queue");

	// An entry without a byte is always an end marker
	a_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && !dout.out_valid) |-> dout.out_end)
		else $error("empty result without end marker");
`endif

endmodule
